### rtl/core/rdm_pkg.sv
`default_nettype none

package rdm_pkg;

   localparam int COORD_W  = 11;
   localparam int CENTER_W = 15;
   localparam int RADIUS_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;

   localparam logic [RADIUS_W-1:0] RADIUS_SAT = 16'hFFFF;

   typedef struct packed {
      logic start;
   } sqrt_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

`default_nettype wire

### rtl/core/rdm_if.sv
`default_nettype none

interface rdm_req_if;
   logic                        valid;
   logic                        ready;
   logic [rdm_pkg::COORD_W-1:0] column;
   logic [rdm_pkg::COORD_W-1:0] row;
   logic                        frame_start;

   modport source (output valid, output column, output row, output frame_start, input ready);
   modport sink   (input valid, input column, input row, input frame_start, output ready);
endinterface

interface rdm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rdm_pkg::RADIUS_W-1:0] radius;
   logic [rdm_pkg::RADIUS_W-1:0] max_radius_out;

   modport source (output valid, output radius, output max_radius_out, input ready);
   modport sink   (input valid, input radius, input max_radius_out, output ready);
endinterface

interface rdm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rdm_pkg::CSR_IDX_W-1:0] index;
   logic [rdm_pkg::CENTER_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/radial_distance_map.sv
// Radial distance map. Each request beat carries a pixel column and row; the
// response beat gives the floor Euclidean distance from the centre held in
// the csr registers (index 0 centre column, index 1 centre line, both in
// 1/2^FRAC_BITS pixel) and the running peak, which frame_start restarts.
// One pixel is in flight at a time: a shared multiplier squares dx then dy,
// then a one-bit-per-cycle square-root unit forms a ROOT_W-bit root (16 bits
// at the default FRAC_BITS of 4, 20 at 8). A finished result is held in the
// response register, so the next pixel is taken while it waits; the next
// result stalls until that register is free. Radii above 65535 saturate.

`default_nettype none

module radial_distance_map #(
   parameter int FRAC_BITS = 4
) (
   input wire         clock,
   input wire         reset,
   rdm_req_if.sink    req,
   rdm_rsp_if.source  rsp,
   rdm_csr_if.sink    csr
);

   localparam int POS_W  = rdm_pkg::COORD_W + FRAC_BITS;
   localparam int OFF_W  = (POS_W > rdm_pkg::CENTER_W) ? POS_W : rdm_pkg::CENTER_W;
   localparam int SQ_W   = 2 * OFF_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int EXT_W  = (ROOT_W > rdm_pkg::RADIUS_W) ? ROOT_W : rdm_pkg::RADIUS_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   logic [rdm_pkg::CENTER_W-1:0] center_x_ff, center_x_in;
   logic [rdm_pkg::CENTER_W-1:0] center_y_ff, center_y_in;

   logic [OFF_W-1:0] dx_ff, dx_in;
   logic [OFF_W-1:0] dy_ff, dy_in;
   logic             fs_ff, fs_in;
   logic [SQ_W-1:0]  prod_ff, prod_in;
   logic [SQ_W-1:0]  acc_ff,  acc_in;

   logic [rdm_pkg::RADIUS_W-1:0] peak_ff, peak_in;
   logic [rdm_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [rdm_pkg::RADIUS_W-1:0] max_out_ff, max_out_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [OFF_W-1:0] px, py, cx, cy, mul_a;
   logic [SUM_W-1:0] sum;
   logic [EXT_W-1:0] root_ext;
   logic [rdm_pkg::RADIUS_W-1:0] rad_sat;
   logic             req_take, rsp_load;

   rdm_pkg::sqrt_ctrl_type sq_ctrl;
   rdm_pkg::sqrt_stat_type sq_stat;
   logic [ROOT_W-1:0]      sq_root;

   rdm_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sq_ctrl),
      .radicand (RAD_W'(sum)),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      px = OFF_W'({req.column, {FRAC_BITS{1'b0}}});
      py = OFF_W'({req.row, {FRAC_BITS{1'b0}}});
      cx = OFF_W'(center_x_ff);
      cy = OFF_W'(center_y_ff);
      mul_a   = (state_ff == ST_SQX) ? dx_ff : dy_ff;
      prod_in = SQ_W'(mul_a) * SQ_W'(mul_a);
      sum     = SUM_W'(acc_ff) + SUM_W'(prod_ff);
      root_ext = EXT_W'(sq_root);
      rad_sat  = (root_ext > EXT_W'(rdm_pkg::RADIUS_SAT)) ? rdm_pkg::RADIUS_SAT
                                                          : root_ext[rdm_pkg::RADIUS_W-1:0];
      sq_ctrl.start = (state_ff == ST_SUM);
      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

      dx_in = (px >= cx) ? px - cx : cx - px;
      dy_in = (py >= cy) ? py - cy : cy - py;
      fs_in = req.frame_start;
      acc_in = prod_ff;

      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr.valid) begin
         unique case (csr.index)
            rdm_pkg::CSR_CENTER_X: center_x_in = csr.data;
            rdm_pkg::CSR_CENTER_Y: center_y_in = csr.data;
            default: ;
         endcase
      end

      peak_in    = peak_ff;
      radius_in  = radius_ff;
      max_out_in = max_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (rsp_load) begin
         peak_in      = (fs_ff || rad_sat > peak_ff) ? rad_sat : peak_ff;
         radius_in    = rad_sat;
         max_out_in   = peak_in;
         rsp_valid_in = 1'b1;
      end

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_ROOT;
         ST_ROOT: if (sq_stat.done) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         fs_ff <= fs_in;
      end
      if (state_ff == ST_SQX || state_ff == ST_SQY) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_SQY) begin
         acc_ff <= acc_in;
      end
      radius_ff  <= radius_in;
      max_out_ff <= max_out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.radius         = radius_ff;
   assign rsp.max_radius_out = max_out_ff;

   a_idle_root_quiet: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !sq_stat.busy)
      else $error("root unit busy while taking a pixel");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.max_radius_out >= rsp.radius)
      else $error("peak below radius");

   a_done_in_root: assert property (@(posedge clock) disable iff (reset)
      sq_stat.done |-> state_ff == ST_ROOT)
      else $error("root done outside root phase");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done phase");

endmodule

`default_nettype wire

### rtl/core/rdm_sqrt.sv
`default_nettype none

module rdm_sqrt #(
   parameter int ROOT_W = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  rdm_pkg::sqrt_ctrl_type      ctrl,
   input  wire  [2*ROOT_W-1:0]         radicand,
   output rdm_pkg::sqrt_stat_type      stat,
   output logic [ROOT_W-1:0]           root
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0] rad_ff,  rad_in;
   logic [REM_W-1:0] rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;
   logic             fits;

   // one result bit per cycle: two radicand bits shifted into the remainder
   always_comb begin
      rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      diff   = rem_sh - trial;
      fits   = (rem_sh >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

`default_nettype wire
